[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Each macro states one concurrent
// property, clocked on the rising edge and disabled during reset. Synthesis
// builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/cbpm_pkg.sv]
// ----------------------------------------------------------------------------
// cbpm_pkg
// Types and constants of the comparison bit pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpm_pkg;

    // Widest pattern and the width of one sample.
    localparam int MAX_PATTERN_BITS = 64;
    localparam int SAMPLE_WIDTH     = 32;

    // Shortest usable pattern length.
    localparam int QGRAM_MIN = 8;

    // Width that holds a pattern length up to and including the maximum.
    localparam int LEN_W = $clog2(MAX_PATTERN_BITS + 1);

    // Sample counter and match start width.
    localparam int COUNT_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MAX_PATTERN_BITS;

    // Reset value of the pattern length register.
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(QGRAM_MIN);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BITS = 1'b0,
        REG_PATTERN_LEN  = 1'b1
    } cfg_idx_e;

    // Pattern settings as the match logic sees them: the expected history
    // bits, the mask of history bits in use and the effective length.
    typedef struct packed {
        logic [MAX_PATTERN_BITS-1:0] expected;
        logic [MAX_PATTERN_BITS-1:0] mask;
        logic [LEN_W-1:0]            len;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/cbpm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cbpm_cfg_regs
// Configuration registers. Holds the pattern and its length, clamps the
// length to the legal range and lines the pattern up with the history.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpm_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbpm_pkg::CFG_DATA_W-1:0] cfg_data,
    output cbpm_pkg::cfg_t                      cfg
);

    import cbpm_pkg::*;

    logic [MAX_PATTERN_BITS-1:0] pattern_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [LEN_W-1:0]            eff_len;
    logic [LEN_W-1:0]            shift_amt;
    logic [MAX_PATTERN_BITS-1:0] pattern_rev;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            len_reg     <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_e'(cfg_index))
                REG_PATTERN_BITS: pattern_reg <= cfg_data[MAX_PATTERN_BITS-1:0];
                REG_PATTERN_LEN:  len_reg     <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the length to the supported range.
    always_comb
    begin
        if (len_reg < LEN_W'(QGRAM_MIN))
            eff_len = LEN_W'(QGRAM_MIN);
        else if (len_reg > LEN_W'(MAX_PATTERN_BITS))
            eff_len = LEN_W'(MAX_PATTERN_BITS);
        else
            eff_len = len_reg;
    end

    // Pattern bit t pairs with history bit len-1-t, so the pattern is
    // reversed and then shifted down until its bit 0 sits at history bit
    // len-1.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BITS; i++)
        begin
            pattern_rev[i] = pattern_reg[MAX_PATTERN_BITS-1-i];
        end
    end

    assign shift_amt    = LEN_W'(MAX_PATTERN_BITS) - eff_len;
    assign cfg.expected = pattern_rev >> shift_amt;
    assign cfg.mask     = ~({MAX_PATTERN_BITS{1'b1}} << eff_len);
    assign cfg.len      = eff_len;

endmodule

`default_nettype wire

[rtl/core/cbpm_match_core.sv]
// ----------------------------------------------------------------------------
// cbpm_match_core
// Comparison history, sample counter and window match. Each step forms one
// comparison bit, shifts it into the history, checks the window and loads
// the result register; the first sample's bit is not shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpm_match_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step,
    input  wire logic [cbpm_pkg::SAMPLE_WIDTH-1:0] cur_sample,
    input  wire cbpm_pkg::cfg_t                   cfg,
    output logic                                  res_free,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cbpm_pkg::COUNT_W-1:0]          match_start
);

    import cbpm_pkg::*;

    `include "assert_macros.svh"

    logic [SAMPLE_WIDTH-1:0]     prev_reg;
    logic [MAX_PATTERN_BITS-1:0] hist_reg;
    logic [MAX_PATTERN_BITS-1:0] hist_next;
    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          len_ext;
    logic [COUNT_W-1:0]          start_next;
    logic                        res_valid_reg;
    logic [COUNT_W-1:0]          start_reg;
    logic                        cmp_bit;
    logic                        hit;

    // Comparison bit, new history and window check.
    always_comb
    begin
        cmp_bit    = $signed(prev_reg) > $signed(cur_sample);
        hist_next  = {hist_reg[MAX_PATTERN_BITS-2:0], cmp_bit};
        len_ext    = COUNT_W'(cfg.len);
        start_next = count_reg - len_ext;
        hit        = (count_reg != '0) && (count_reg >= len_ext) &&
                     (((hist_next ^ cfg.expected) & cfg.mask) == '0);
    end

    // The result register can take a new result when empty or being drained.
    assign res_free    = !res_valid_reg || out_ready;
    assign out_valid   = res_valid_reg;
    assign match_start = start_reg;

    // Control state: history, counter and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            if (count_reg != '0)
                hist_reg <= hist_next;
            if (count_reg != '1)
                count_reg <= count_reg + 1'b1;
            res_valid_reg <= hit;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Payload: previous sample and match start.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            prev_reg <= cur_sample;
            if (hit)
                start_reg <= start_next;
        end
    end

    // The counter stays saturated once it reaches its top value.
    `ASSERT_NEXT(a_count_sat, clk, rst_n, count_reg == '1, count_reg == '1)
    // The first sample never yields a result.
    `ASSERT_NEXT(a_first_no_result, clk, rst_n, step && (count_reg == '0), !res_valid_reg)
    // A reported window always starts before the newest sample.
    `ASSERT_IMPLIES(a_start_order, clk, rst_n, res_valid_reg, start_reg < count_reg)
    // A step is only taken when the result register has room.
    `ASSERT_IMPLIES(a_step_room, clk, rst_n, step, res_free)

endmodule

`default_nettype wire

[rtl/core/comparison_bit_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// comparison_bit_pattern_matcher
// Streams signed samples, forms a bit per neighbor pair (1 when the earlier
// sample is greater) and reports the start index of every window whose bits
// equal the configured pattern.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle as long as results are drained. A
// sample is held in the input register, then compared with its predecessor,
// shifted into the comparison history and checked against the pattern in a
// single step that loads the result register, which drives match_start. The
// result register is the only point of backpressure: in_ready drops only
// while a result waits and out_ready is low. Write pattern_bits and
// pattern_len only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module comparison_bit_pattern_matcher (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [cbpm_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cbpm_pkg::COUNT_W-1:0]          match_start,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cbpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import cbpm_pkg::*;

    cfg_t                    cfg;
    logic                    s1_valid_reg;
    logic [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                    res_free;
    logic                    step;

    // Configuration registers.
    cbpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input stage: advances into the match step when the result side has room.
    assign step     = s1_valid_reg && res_free;
    assign in_ready = !s1_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_sample_reg <= sample;
    end

    // Match step and result register.
    cbpm_match_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cur_sample  (s1_sample_reg),
        .cfg         (cfg),
        .res_free    (res_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_start (match_start)
    );

endmodule

`default_nettype wire
